### src/dsma_pkg.sv
// Shared types and constants for the dual SMA crossover signal block.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none
package dsma_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int PRICE_BITS_DEF = 32;
    localparam int SUM_OUT_W      = 38;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 7;

    localparam int SHORT_RESET = 50;
    localparam int LONG_RESET  = 60;

    // result queue behind the compare pipeline
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        SIG_HOLD = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } t_signal;

    typedef enum logic [1:0] {
        REL_NONE  = 2'd0,
        REL_ABOVE = 2'd1,
        REL_BELOW = 2'd2,
        REL_EQUAL = 2'd3
    } t_rel;

endpackage
`default_nettype wire

### src/dsma_if.sv
// Valid/ready channel interfaces: price input, crossover result, config write.
// Depends on dsma_pkg.
`default_nettype none
interface dsma_price_if #(
    parameter int W = dsma_pkg::PRICE_BITS_DEF
);
    logic         valid;
    logic         ready;
    logic [W-1:0] price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

interface dsma_result_if;
    import dsma_pkg::*;
    logic                 valid;
    logic                 ready;
    t_signal              signal;
    logic [SUM_OUT_W-1:0] short_total;
    logic [SUM_OUT_W-1:0] long_total;

    modport source (output valid, output signal, output short_total, output long_total,
                    input ready);
    modport sink   (input valid, input signal, input short_total, input long_total,
                    output ready);
endinterface

interface dsma_cfg_if;
    import dsma_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/dual_sma_crossover_signal.sv
// Dual SMA crossover: price ring in a 2-read/1-write memory, running sums, exact compare.
// A price passes the s1, s2 and s3 stage registers and then the result queue before its result is
// offered. Throughput: one price per cycle, set by the sum update loop; input stalls when the
// 8-entry result queue, counting the items in the 3 pipeline stages, would overflow.
// Reset (synchronous, active low) and window config writes restart the history: ring position,
// count, sums and last relation go to zero. The ring memory itself is never cleared.
`default_nettype none
module dual_sma_crossover_signal #(
    parameter int MAX_WINDOW = dsma_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = dsma_pkg::PRICE_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    dsma_price_if.sink       i_price,
    dsma_result_if.source    o_result,
    dsma_cfg_if.sink         i_cfg
);
    import dsma_pkg::*;

    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int EW     = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = PRICE_BITS + $clog2(MAX_WINDOW);
    localparam int PROD_W = SUM_W + EW;

    function automatic logic [EW-1:0] eff_win(input logic [CFG_DATA_W-1:0] w);
        logic [EW-1:0] r;
        if (w == '0) begin
            r = EW'(1);
        end else if (int'(w) > MAX_WINDOW) begin
            r = EW'(MAX_WINDOW);
        end else begin
            r = EW'(w);
        end
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic [EW-1:0] r_short_win, r_long_win;
    logic          cfg_we;
    logic          cfg_hit;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid && cfg_hit;

    always_comb begin
        unique case (i_cfg.index)
            CFG_SHORT_WINDOW: cfg_hit = 1'b1;
            CFG_LONG_WINDOW:  cfg_hit = 1'b1;
            default:          cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_win <= eff_win(CFG_DATA_W'(SHORT_RESET));
            r_long_win  <= eff_win(CFG_DATA_W'(LONG_RESET));
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_SHORT_WINDOW) begin
                r_short_win <= eff_win(i_cfg.data);
            end
            if (i_cfg.index == CFG_LONG_WINDOW) begin
                r_long_win <= eff_win(i_cfg.data);
            end
        end
    end

    // ---------------- stage 0: accept, ring access ----------------
    logic                  in_acc;
    logic [PRICE_BITS-1:0] price_in;
    logic [AW-1:0]         r_wp, n_wp;
    logic [EW-1:0]         r_seen, n_seen;
    logic [EW-1:0]         need;
    logic [EW:0]           wp_x, addr_s_x, addr_l_x;
    logic [AW-1:0]         rd_addr_s, rd_addr_l;

    logic [PRICE_BITS-1:0] r_hist [MAX_WINDOW];
    logic [PRICE_BITS-1:0] r_old_s, r_old_l;

    logic                  r_s1_valid, r_s1_report, r_s1_drop_s, r_s1_drop_l;
    logic [PRICE_BITS-1:0] r_s1_price;

    assign price_in = PRICE_BITS'(i_price.price);
    assign in_acc   = i_price.valid && i_price.ready;
    assign need     = (r_short_win > r_long_win) ? r_short_win : r_long_win;

    always_comb begin
        wp_x = (EW+1)'(r_wp);
        // oldest slot of each window, modulo ring depth
        if (wp_x >= (EW+1)'(r_short_win)) begin
            addr_s_x = wp_x - (EW+1)'(r_short_win);
        end else begin
            addr_s_x = wp_x + (EW+1)'(MAX_WINDOW) - (EW+1)'(r_short_win);
        end
        if (wp_x >= (EW+1)'(r_long_win)) begin
            addr_l_x = wp_x - (EW+1)'(r_long_win);
        end else begin
            addr_l_x = wp_x + (EW+1)'(MAX_WINDOW) - (EW+1)'(r_long_win);
        end
        rd_addr_s = addr_s_x[AW-1:0];
        rd_addr_l = addr_l_x[AW-1:0];
        n_wp      = (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
        n_seen    = (r_seen < EW'(MAX_WINDOW)) ? r_seen + 1'b1 : r_seen;
    end

    // read-before-write: a full-depth window reads the slot being overwritten
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hist[r_wp] <= price_in;
        end
        r_old_s <= r_hist[rd_addr_s];
        r_old_l <= r_hist[rd_addr_l];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            r_wp       <= '0;
            r_seen     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
            if (in_acc) begin
                r_wp   <= n_wp;
                r_seen <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_price  <= price_in;
        r_s1_drop_s <= (r_seen >= r_short_win);
        r_s1_drop_l <= (r_seen >= r_long_win);
        r_s1_report <= (n_seen >= need);
    end

    // ---------------- stage 1: running sums ----------------
    logic [SUM_W-1:0] r_short_sum, r_long_sum;
    logic [SUM_W-1:0] n_short_sum, n_long_sum;
    logic             r_s2_valid;

    always_comb begin
        n_short_sum = r_short_sum + SUM_W'(r_s1_price)
                    - (r_s1_drop_s ? SUM_W'(r_old_s) : '0);
        n_long_sum  = r_long_sum + SUM_W'(r_s1_price)
                    - (r_s1_drop_l ? SUM_W'(r_old_l) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            r_short_sum <= '0;
            r_long_sum  <= '0;
            r_s2_valid  <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_report;
            if (r_s1_valid) begin
                r_short_sum <= n_short_sum;
                r_long_sum  <= n_long_sum;
            end
        end
    end

    // ---------------- stage 2: cross products ----------------
    logic              r_s3_valid;
    logic [PROD_W-1:0] r_prod_a, r_prod_b;
    logic [SUM_W-1:0]  r_s3_short, r_s3_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_a   <= PROD_W'(r_short_sum) * PROD_W'(r_long_win);
        r_prod_b   <= PROD_W'(r_long_sum) * PROD_W'(r_short_win);
        r_s3_short <= r_short_sum;
        r_s3_long  <= r_long_sum;
    end

    // ---------------- stage 3: compare, signal ----------------
    t_rel    r_prev_rel;
    t_rel    rel;
    t_signal sig;
    logic    push;

    always_comb begin
        if (r_prod_a > r_prod_b) begin
            rel = REL_ABOVE;
        end else if (r_prod_a < r_prod_b) begin
            rel = REL_BELOW;
        end else begin
            rel = REL_EQUAL;
        end
        sig = SIG_HOLD;
        if (rel == REL_ABOVE && r_prev_rel != REL_ABOVE) begin
            sig = SIG_BUY;
        end else if (rel == REL_BELOW && r_prev_rel != REL_BELOW) begin
            sig = SIG_SELL;
        end
        // first full comparison is only recorded
        push = r_s3_valid && (r_prev_rel != REL_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            r_prev_rel <= REL_NONE;
        end else if (r_s3_valid) begin
            r_prev_rel <= rel;
        end
    end

    // ---------------- result queue ----------------
    t_signal              r_fifo_sig   [FIFO_DEPTH];
    logic [SUM_OUT_W-1:0] r_fifo_short [FIFO_DEPTH];
    logic [SUM_OUT_W-1:0] r_fifo_long  [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]     r_fifo_cnt;
    logic [FIFO_AW:0]     occupancy;
    logic                 pop;

    assign pop       = o_result.valid && o_result.ready;
    // reserve a slot for every item still in the pipeline
    assign occupancy = r_fifo_cnt + (FIFO_AW+1)'(r_s1_valid) + (FIFO_AW+1)'(r_s2_valid)
                     + (FIFO_AW+1)'(r_s3_valid);
    assign i_price.ready = (occupancy < (FIFO_AW+1)'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo_sig[r_wr_ptr]   <= sig;
            r_fifo_short[r_wr_ptr] <= SUM_OUT_W'(r_s3_short);
            r_fifo_long[r_wr_ptr]  <= SUM_OUT_W'(r_s3_long);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_fifo_cnt <= r_fifo_cnt + 1'b1;
                2'b01:   r_fifo_cnt <= r_fifo_cnt - 1'b1;
                default: r_fifo_cnt <= r_fifo_cnt;
            endcase
        end
    end

    assign o_result.valid       = (r_fifo_cnt != '0);
    assign o_result.signal      = r_fifo_sig[r_rd_ptr];
    assign o_result.short_total = r_fifo_short[r_rd_ptr];
    assign o_result.long_total  = r_fifo_long[r_rd_ptr];

    // ---------------- assertions ----------------
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_fifo_cnt < (FIFO_AW+1)'(FIFO_DEPTH)) || pop)
        else $error("result pushed into full queue");

    a_rel_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && !cfg_we) |=> (r_prev_rel != REL_NONE))
        else $error("comparison not recorded");

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_wp) < MAX_WINDOW)
        else $error("ring position out of range");

endmodule
`default_nettype wire

### tb/tb_dual_sma_crossover_signal.sv
`timescale 1ns / 1ps
// Self-checking testbench for dual_sma_crossover_signal: directed table, then random price runs.
// Depends on dsma_pkg and the channel interfaces in dsma_if; checks each result against table or predictor.
module tb_dual_sma_crossover_signal;
    import dsma_pkg::*;

    localparam int          RAND_ITEMS     = 930;
    localparam int          SETTLE_CYCLES  = 12;
    localparam int          HOLD_CYCLES    = 200;
    localparam int          STALL_PHASE    = 5;
    localparam int unsigned TIMEOUT_CYCLES = 400_000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(15);

    typedef struct packed {
        t_signal              signal;
        logic [SUM_OUT_W-1:0] short_total;
        logic [SUM_OUT_W-1:0] long_total;
    } t_xover;

    typedef enum logic [1:0] {
        ROW_PRICE,
        ROW_CHECKED,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [31:0]           price;
        t_signal               signal;
        logic [SUM_OUT_W-1:0]  short_total;
        logic [SUM_OUT_W-1:0]  long_total;
    } t_stim_row;

    typedef enum {
        RUN_TREND,
        RUN_NOISE,
        RUN_EXTREME,
        RUN_FLAT
    } t_tick_run;

    localparam int DIR_ROWS = 28;

    // Typed expectations only where the sums are obvious (windows 1 and 2, extreme prices).
    t_stim_row dir_rows [DIR_ROWS] = '{
        '{ROW_PRICE,   '0, '0, 32'hFFFF_FFFF, SIG_HOLD, '0, '0},
        '{ROW_PRICE,   '0, '0, 32'h0000_0000, SIG_HOLD, '0, '0},
        '{ROW_PRICE,   '0, '0, 32'h1234_5678, SIG_HOLD, '0, '0},
        '{ROW_REG,     CFG_SHORT_WINDOW, 7'd1, '0, SIG_HOLD, '0, '0},
        '{ROW_REG,     CFG_LONG_WINDOW,  7'd2, '0, SIG_HOLD, '0, '0},
        '{ROW_PRICE,   '0, '0, 32'hFFFF_FFFF, SIG_HOLD, '0, '0},
        '{ROW_PRICE,   '0, '0, 32'hFFFF_FFFF, SIG_HOLD, '0, '0},
        '{ROW_CHECKED, '0, '0, 32'h0000_0000, SIG_SELL, 38'h0, 38'h0_FFFF_FFFF},
        '{ROW_CHECKED, '0, '0, 32'h0000_0000, SIG_HOLD, 38'h0, 38'h0},
        '{ROW_CHECKED, '0, '0, 32'hFFFF_FFFF, SIG_BUY,  38'h0_FFFF_FFFF, 38'h0_FFFF_FFFF},
        '{ROW_CHECKED, '0, '0, 32'hFFFF_FFFF, SIG_HOLD, 38'h0_FFFF_FFFF, 38'h1_FFFF_FFFE},
        '{ROW_CHECKED, '0, '0, 32'h0000_0001, SIG_SELL, 38'h1, 38'h1_0000_0000},
        '{ROW_CHECKED, '0, '0, 32'h0000_0001, SIG_HOLD, 38'h1, 38'h2},
        // write to an index past the register list must not restart the history
        '{ROW_REG,     CFG_UNUSED_IDX,   7'h7F, '0, SIG_HOLD, '0, '0},
        '{ROW_CHECKED, '0, '0, 32'hFFFF_FFFF, SIG_BUY,  38'h0_FFFF_FFFF, 38'h1_0000_0000},
        // zero long window counts as one, short longer than long
        '{ROW_REG,     CFG_SHORT_WINDOW, 7'd2, '0, SIG_HOLD, '0, '0},
        '{ROW_REG,     CFG_LONG_WINDOW,  7'd0, '0, SIG_HOLD, '0, '0},
        '{ROW_PRICE,   '0, '0, 32'd5,  SIG_HOLD, '0, '0},
        '{ROW_PRICE,   '0, '0, 32'd3,  SIG_HOLD, '0, '0},
        '{ROW_PRICE,   '0, '0, 32'd10, SIG_HOLD, '0, '0},
        '{ROW_PRICE,   '0, '0, 32'd10, SIG_HOLD, '0, '0},
        '{ROW_PRICE,   '0, '0, 32'd0,  SIG_HOLD, '0, '0},
        // equal windows keep the averages equal: hold only
        '{ROW_REG,     CFG_SHORT_WINDOW, 7'd3, '0, SIG_HOLD, '0, '0},
        '{ROW_REG,     CFG_LONG_WINDOW,  7'd3, '0, SIG_HOLD, '0, '0},
        '{ROW_PRICE,   '0, '0, 32'd7, SIG_HOLD, '0, '0},
        '{ROW_PRICE,   '0, '0, 32'd9, SIG_HOLD, '0, '0},
        '{ROW_PRICE,   '0, '0, 32'd1, SIG_HOLD, '0, '0},
        '{ROW_PRICE,   '0, '0, 32'd4, SIG_HOLD, '0, '0}
    };

    logic clk;
    logic rst_n;

    dsma_price_if #(.W(PRICE_BITS_DEF)) price_if ();
    dsma_result_if                      result_if ();
    dsma_cfg_if                         cfg_if ();

    dual_sma_crossover_signal u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_price  (price_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    // predictor state
    logic [31:0]           px_ring [MAX_WINDOW_DEF];
    logic [5:0]            ring_wr;
    int unsigned           ring_fill;
    logic [39:0]           short_sum;
    logic [39:0]           long_sum;
    t_rel                  last_rel;
    logic [CFG_DATA_W-1:0] short_reg = CFG_DATA_W'(SHORT_RESET);
    logic [CFG_DATA_W-1:0] long_reg  = CFG_DATA_W'(LONG_RESET);

    t_xover      pending_results [$];
    int unsigned err_cnt      = 0;
    int unsigned src_idle_pct = 11;
    int unsigned sink_idle_pct = 54;
    int unsigned stall_req    = 0;
    int unsigned cycle_cnt    = 0;

    // price generator state
    t_tick_run   run_kind   = RUN_TREND;
    int unsigned run_left   = 0;
    bit          trend_up   = 1'b1;
    int unsigned trend_step = 0;
    logic [31:0] walk_px    = 32'h8000_0000;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        while (cycle_cnt < TIMEOUT_CYCLES) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("dual_sma_crossover_signal test failed");
        $finish;
    end

    function automatic int unsigned clamp_win(input logic [CFG_DATA_W-1:0] w);
        if (w == 0) return 1;
        if (w > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
        return 32'(w);
    endfunction

    function automatic void clear_history();
        ring_wr   = '0;
        ring_fill = 0;
        short_sum = '0;
        long_sum  = '0;
        last_rel  = REL_NONE;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_SHORT_WINDOW) begin
            short_reg = val;
            clear_history();
        end else if (idx == CFG_LONG_WINDOW) begin
            long_reg = val;
            clear_history();
        end
    endfunction

    // Advances the predictor by one price; returns 1 when the price yields a result.
    function automatic bit predict_crossover(input logic [31:0] px, output t_xover res);
        int unsigned s;
        int unsigned l;
        int unsigned need;
        logic [63:0] lhs;
        logic [63:0] rhs;
        t_rel        rel;
        bit          has;
        res  = '0;
        has  = 1'b0;
        s    = clamp_win(short_reg);
        l    = clamp_win(long_reg);
        need = (s > l) ? s : l;
        if (ring_fill >= s) short_sum -= 40'(px_ring[6'(ring_wr - s)]);
        if (ring_fill >= l) long_sum  -= 40'(px_ring[6'(ring_wr - l)]);
        px_ring[ring_wr] = px;
        short_sum += 40'(px);
        long_sum  += 40'(px);
        ring_wr = ring_wr + 6'd1;
        if (ring_fill < MAX_WINDOW_DEF) ring_fill++;
        if (ring_fill < need) return 1'b0;
        // exact average compare by cross-multiplying with the other window
        lhs = 64'(short_sum) * 64'(l);
        rhs = 64'(long_sum) * 64'(s);
        if (lhs > rhs) rel = REL_ABOVE;
        else if (lhs < rhs) rel = REL_BELOW;
        else rel = REL_EQUAL;
        if (last_rel != REL_NONE) begin
            res.signal = SIG_HOLD;
            if (rel == REL_ABOVE && last_rel != REL_ABOVE) res.signal = SIG_BUY;
            else if (rel == REL_BELOW && last_rel != REL_BELOW) res.signal = SIG_SELL;
            res.short_total = short_sum[SUM_OUT_W-1:0];
            res.long_total  = long_sum[SUM_OUT_W-1:0];
            has = 1'b1;
        end
        last_rel = rel;
        return has;
    endfunction

    // Mostly trending runs so the averages cross; some noise, extremes and flat stretches.
    function automatic logic [31:0] market_tick();
        longint      nxt;
        longint      d;
        int unsigned pick;
        if (run_left == 0) begin
            pick = $urandom_range(99);
            if (pick < 70) run_kind = RUN_TREND;
            else if (pick < 85) run_kind = RUN_NOISE;
            else if (pick < 95) run_kind = RUN_EXTREME;
            else run_kind = RUN_FLAT;
            run_left   = $urandom_range(3, 24);
            trend_up   = 1'($urandom_range(1));
            trend_step = $urandom_range(0, 32'd1 << $urandom_range(4, 26));
            if ($urandom_range(9) == 0) walk_px = $urandom;
        end
        run_left--;
        case (run_kind)
            RUN_TREND: begin
                d   = longint'(trend_step) + longint'($urandom_range(0, trend_step >> 2));
                nxt = trend_up ? longint'(walk_px) + d : longint'(walk_px) - d;
                if (nxt < 0) nxt = 0;
                if (nxt > 64'h0_FFFF_FFFF) nxt = 64'h0_FFFF_FFFF;
                walk_px = nxt[31:0];
            end
            RUN_NOISE:   walk_px = $urandom;
            RUN_EXTREME: walk_px = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default:     walk_px = walk_px;
        endcase
        return walk_px;
    endfunction

    // Stops offering prices and waits until every pending result has been checked.
    task automatic flush_pending();
        price_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        flush_pending();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        apply_reg(idx, val);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_price(input logic [31:0] px, input bit typed, input t_xover typed_res);
        t_xover res;
        bit     has;
        while ($urandom_range(99) < src_idle_pct) begin
            price_if.valid <= 1'b0;
            @(posedge clk);
        end
        price_if.valid <= 1'b1;
        price_if.price <= px;
        @(posedge clk);
        while (!price_if.ready) @(posedge clk);
        has = predict_crossover(px, res);
        if (typed) pending_results = {pending_results, typed_res};
        else if (has) pending_results = {pending_results, res};
    endtask

    // Result side: checks each transaction, random back-pressure, long hold-off on request.
    initial begin : result_sink
        int unsigned stall_taken;
        int unsigned stall_left;
        t_xover      want;
        stall_taken = 0;
        stall_left  = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: signal %0d short_total %0h long_total %0h",
                           result_if.signal, result_if.short_total, result_if.long_total);
                    err_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (want.signal !== result_if.signal) begin
                        $error("signal: expected %0d, got %0d", want.signal, result_if.signal);
                        err_cnt++;
                    end
                    if (want.short_total !== result_if.short_total) begin
                        $error("short_total: expected %0h, got %0h",
                               want.short_total, result_if.short_total);
                        err_cnt++;
                    end
                    if (want.long_total !== result_if.long_total) begin
                        $error("long_total: expected %0h, got %0h",
                               want.long_total, result_if.long_total);
                        err_cnt++;
                    end
                end
            end
            if (stall_req != stall_taken) begin
                stall_taken = stall_req;
                stall_left  = HOLD_CYCLES;
            end
            if (stall_left != 0) begin
                result_if.ready <= 1'b0;
                stall_left--;
            end else begin
                result_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin : main_seq
        logic [CFG_DATA_W-1:0] s_raw;
        logic [CFG_DATA_W-1:0] l_raw;
        int unsigned           need;
        int unsigned           n_items;
        int unsigned           pause_at;
        int unsigned           rand_sent;
        int unsigned           phase;
        t_xover                row_res;
        rst_n          <= 1'b0;
        price_if.valid <= 1'b0;
        price_if.price <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= '0;
        cfg_if.data    <= '0;
        clear_history();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            row_res = '{dir_rows[r].signal, dir_rows[r].short_total, dir_rows[r].long_total};
            case (dir_rows[r].kind)
                ROW_REG:     write_reg(dir_rows[r].idx, dir_rows[r].val);
                ROW_CHECKED: send_price(dir_rows[r].price, 1'b1, row_res);
                default:     send_price(dir_rows[r].price, 1'b0, row_res);
            endcase
        end

        rand_sent = 0;
        phase     = 0;
        row_res   = '0;
        while (rand_sent < RAND_ITEMS) begin
            case (phase)
                0: begin s_raw = CFG_DATA_W'(SHORT_RESET); l_raw = CFG_DATA_W'(LONG_RESET); end
                1: begin s_raw = 7'd64;  l_raw = 7'd64;  end
                2: begin s_raw = 7'd0;   l_raw = 7'd127; end
                3: begin s_raw = 7'd127; l_raw = 7'd0;   end
                4: begin s_raw = 7'd1;   l_raw = 7'd1;   end
                STALL_PHASE: begin s_raw = 7'd1; l_raw = 7'd2; end
                default: begin
                    if ($urandom_range(4) == 0) begin
                        s_raw = CFG_DATA_W'($urandom);
                        l_raw = CFG_DATA_W'($urandom);
                    end else begin
                        s_raw = CFG_DATA_W'($urandom_range(1, 10));
                        l_raw = CFG_DATA_W'($urandom_range(1, 24));
                    end
                end
            endcase
            if ($urandom_range(1)) begin
                write_reg(CFG_SHORT_WINDOW, s_raw);
                write_reg(CFG_LONG_WINDOW, l_raw);
            end else begin
                write_reg(CFG_LONG_WINDOW, l_raw);
                write_reg(CFG_SHORT_WINDOW, s_raw);
            end
            need = (clamp_win(s_raw) > clamp_win(l_raw)) ? clamp_win(s_raw) : clamp_win(l_raw);
            if (phase == STALL_PHASE) begin
                n_items  = need + 80;
                pause_at = need + 60;
            end else begin
                n_items  = need + $urandom_range(15, 70);
                pause_at = ($urandom_range(3) == 0) ? $urandom_range(1, n_items - 1) : n_items;
            end
            for (int unsigned i = 0; i < n_items && rand_sent < RAND_ITEMS; i++) begin
                if (rand_sent < RAND_ITEMS / 3) begin
                    src_idle_pct  = 11;
                    sink_idle_pct = 54;
                end else if (rand_sent < 2 * RAND_ITEMS / 3) begin
                    src_idle_pct  = 54;
                    sink_idle_pct = 11;
                end else begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
                // receiver holds off while prices keep coming, so the result queue fills
                if (phase == STALL_PHASE && i == need + 4) stall_req++;
                if (i == pause_at) begin
                    if ($urandom_range(1))
                        write_reg(CFG_IDX_W'($urandom_range(CFG_LONG_WINDOW + 1, CFG_UNUSED_IDX)),
                                  CFG_DATA_W'($urandom));
                    else
                        flush_pending();
                end
                send_price(market_tick(), 1'b0, row_res);
                rand_sent++;
            end
            phase++;
        end

        flush_pending();
        if (err_cnt == 0)
            $display("dual_sma_crossover_signal test passed");
        else
            $display("dual_sma_crossover_signal test failed");
        $finish;
    end

endmodule
